// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, muted while reset is high
`define ASSERT_CLK(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");

// clocked property, also checked during reset
`define ASSERT_CLK_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("assertion failed");

`endif

// ----- hw/rtl/fpi_pkg.sv -----
package fpi_pkg;

   localparam int N_RULES       = 5;
   localparam int MIDDLE_RULE   = 2;
   localparam int PACKED_FIELDS = 5;
   localparam int FIELD_W       = 12;
   localparam int CFG_W         = 60;
   localparam int HEIGHTS_W     = 32;
   localparam int MU_W          = 16;
   localparam int DRIVE_W       = 16;
   localparam int IN_W          = 12;
   localparam int ERR_W         = 13;
   localparam int CHG_W         = 14;
   localparam int DIFF_W        = 15;
   localparam int DIST_W        = 14;
   localparam int FRAC_BITS     = 15;
   localparam int CSR_IDX_W     = 3;
   localparam int RULE_W        = $clog2(N_RULES);
   localparam int DEN_W         = MU_W + $clog2(N_RULES);
   localparam int PROD_W        = MU_W + 1 + FIELD_W;
   localparam int NUM_W         = PROD_W + $clog2(N_RULES);
   localparam int DIV_W         = NUM_W;
   localparam int CNT_W         = $clog2(DIV_W + 1);
   localparam int INC_W         = FIELD_W + 2;
   localparam int SUM_W         = DRIVE_W + 2;

   localparam logic [RULE_W-1:0] LAST_RULE = RULE_W'(N_RULES - 1);
   localparam logic [RULE_W-1:0] MID_RULE  = RULE_W'(MIDDLE_RULE);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ERROR_CENTERS  = 3'd0,
      CSR_ERROR_WIDTHS   = 3'd1,
      CSR_CHANGE_CENTERS = 3'd2,
      CSR_CHANGE_WIDTHS  = 3'd3,
      CSR_OUTPUT_CENTERS = 3'd4,
      CSR_PEAK_HEIGHTS   = 3'd5,
      CSR_DRIVE_MIN      = 3'd6,
      CSR_DRIVE_MAX      = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MEM,
      ST_MEM_WAIT,
      ST_ACC,
      ST_CENT,
      ST_CENT_WAIT,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic              load;
      logic              mem_write;
      logic              div_mem;
      logic              mem_capture;
      logic              acc;
      logic              div_cent;
      logic              finish;
      logic              chg;
      logic [RULE_W-1:0] rule;
   } cmd_type;

   typedef struct packed {
      logic mem_direct;
      logic div_done;
      logic den_zero;
   } status_type;

   // packed 12-bit field i, zero beyond the packed sets
   function automatic logic [FIELD_W-1:0] field_get(input logic [CFG_W-1:0] r,
                                                    input logic [RULE_W-1:0] i);
      logic [FIELD_W-1:0] f;
      f = '0;
      for (int k = 0; k < PACKED_FIELDS; k++) begin
         if (32'(i) == k) begin
            f = r[k*FIELD_W +: FIELD_W];
         end
      end
      return f;
   endfunction

endpackage

// ----- hw/rtl/fpi_divider.sv -----
module fpi_divider import fpi_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);

   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   diff;
   logic             ge;

   // restoring division, one quotient bit per cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      ge      = shifted >= {1'b0, dvs_ff};
      diff    = shifted - {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- hw/rtl/fpi_datapath.sv -----
module fpi_datapath import fpi_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_write_data,
   input  logic [IN_W-1:0]      req_setpoint,
   input  logic [IN_W-1:0]      req_measured,
   input  cmd_type              cmd,
   output status_type           status,
   output logic [DRIVE_W-1:0]   rsp_drive,
   output logic                 rsp_no_rule_fired
);

   logic [CFG_W-1:0]     err_c_ff, err_w_ff, chg_c_ff, chg_w_ff, out_c_ff;
   logic [HEIGHTS_W-1:0] heights_ff;
   logic [DRIVE_W-1:0]   dmin_ff, dmax_ff;

   logic [ERR_W-1:0]     e_ff, prev_e_ff;
   logic [CHG_W-1:0]     de_ff;
   logic [DRIVE_W-1:0]   prev_drive_ff, drive_ff;
   logic                 none_ff;
   logic [MU_W-1:0]      mu_e_ff [N_RULES];
   logic [MU_W-1:0]      mu_de_ff [N_RULES];
   logic [NUM_W-1:0]     num_ff;
   logic [DEN_W-1:0]     den_ff;

   logic [ERR_W-1:0]     e_in;
   logic [FIELD_W-1:0]   c_sel, w_sel;
   logic [MU_W-1:0]      h_sel;
   logic [CHG_W-1:0]     x_sel;
   logic [DIFF_W-1:0]    diff;
   logic [DIFF_W-1:0]    diff_abs;
   logic [DIST_W-1:0]    abs_dist;
   logic                 w_zero, over;
   logic [MU_W-1:0]      direct_mu;
   logic [MU_W:0]        sub_mu;
   logic [MU_W-1:0]      cap_mu;

   logic [MU_W-1:0]      mu_e_r, mu_de_r, mu_e_mid, mu_de_mid, mu_out;
   logic [PROD_W-1:0]    prod;

   logic                 div_start, div_done;
   logic [DIV_W-1:0]     div_dividend, quotient;
   logic [DEN_W-1:0]     div_divisor;
   logic                 num_neg;
   logic [NUM_W-1:0]     num_abs;

   logic [INC_W-1:0]     q_s, inc, inc_a, lo, hi;
   logic [SUM_W-1:0]     sum, sum_a, sum_b, dmin_x, dmax_x;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         err_c_ff   <= '0;
         err_w_ff   <= 60'h001001001001001;
         chg_c_ff   <= '0;
         chg_w_ff   <= 60'h001001001001001;
         out_c_ff   <= '0;
         heights_ff <= 32'h7FFF7FFF;
         dmin_ff    <= 16'h8000;
         dmax_ff    <= 16'h7FFF;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_ERROR_CENTERS:  err_c_ff   <= csr_write_data;
            CSR_ERROR_WIDTHS:   err_w_ff   <= csr_write_data;
            CSR_CHANGE_CENTERS: chg_c_ff   <= csr_write_data;
            CSR_CHANGE_WIDTHS:  chg_w_ff   <= csr_write_data;
            CSR_OUTPUT_CENTERS: out_c_ff   <= csr_write_data;
            CSR_PEAK_HEIGHTS:   heights_ff <= csr_write_data[HEIGHTS_W-1:0];
            CSR_DRIVE_MIN:      dmin_ff    <= csr_write_data[DRIVE_W-1:0];
            CSR_DRIVE_MAX:      dmax_ff    <= csr_write_data[DRIVE_W-1:0];
            default: ;
         endcase
      end
   end

   assign e_in = ERR_W'($signed(req_setpoint)) - ERR_W'($signed(req_measured));

   // membership of the selected set
   always_comb begin
      c_sel    = cmd.chg ? field_get(chg_c_ff, cmd.rule) : field_get(err_c_ff, cmd.rule);
      w_sel    = cmd.chg ? field_get(chg_w_ff, cmd.rule) : field_get(err_w_ff, cmd.rule);
      h_sel    = cmd.chg ? heights_ff[2*MU_W-1:MU_W] : heights_ff[MU_W-1:0];
      x_sel    = cmd.chg ? de_ff : CHG_W'($signed(e_ff));
      diff     = DIFF_W'($signed(x_sel)) - DIFF_W'($signed(c_sel));
      diff_abs = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
      abs_dist = diff_abs[DIST_W-1:0];
      w_zero   = (w_sel == '0);
      over     = abs_dist > DIST_W'(w_sel);
      direct_mu = (w_zero && abs_dist == '0) ? h_sel : '0;
      sub_mu   = {1'b0, h_sel} - quotient[MU_W:0];
      cap_mu   = sub_mu[MU_W] ? '0 : sub_mu[MU_W-1:0];
   end

   // rule combination for the rule under accumulation
   always_comb begin
      mu_e_r    = mu_e_ff[cmd.rule];
      mu_de_r   = mu_de_ff[cmd.rule];
      mu_e_mid  = mu_e_ff[MIDDLE_RULE];
      mu_de_mid = mu_de_ff[MIDDLE_RULE];
      mu_out    = '0;
      if (mu_e_r != '0 && mu_de_mid != '0) begin
         mu_out = (mu_e_r > mu_de_mid) ? mu_e_r : mu_de_mid;
      end
      if (mu_e_mid != '0 && mu_de_r != '0) begin
         mu_out = (mu_e_mid > mu_de_r) ? mu_e_mid : mu_de_r;
      end
      prod = PROD_W'($signed({1'b0, mu_out})) *
             PROD_W'($signed(field_get(out_c_ff, cmd.rule)));
   end

   // shared divider: membership slope or centroid
   always_comb begin
      num_neg   = num_ff[NUM_W-1];
      num_abs   = num_neg ? (~num_ff + NUM_W'(1)) : num_ff;
      div_start = cmd.div_mem | cmd.div_cent;
      if (cmd.div_cent) begin
         div_dividend = DIV_W'(num_abs);
         div_divisor  = den_ff;
      end else begin
         div_dividend = DIV_W'({abs_dist[FIELD_W-1:0], {FRAC_BITS{1'b0}}});
         div_divisor  = DEN_W'(w_sel);
      end
   end

   fpi_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   // increment and drive clamps
   always_comb begin
      q_s    = {1'b0, quotient[INC_W-2:0]};
      inc    = num_neg ? (~q_s + INC_W'(1)) : q_s;
      hi     = INC_W'($signed(field_get(out_c_ff, LAST_RULE)));
      lo     = INC_W'($signed(field_get(out_c_ff, '0)));
      inc_a  = ($signed(inc) > $signed(hi)) ? hi : inc;
      inc_a  = ($signed(inc_a) <= $signed(lo)) ? lo : inc_a;
      sum    = SUM_W'($signed(prev_drive_ff));
      if (den_ff != '0) begin
         sum = SUM_W'($signed(prev_drive_ff)) + SUM_W'($signed(inc_a));
      end
      dmin_x = SUM_W'($signed(dmin_ff));
      dmax_x = SUM_W'($signed(dmax_ff));
      sum_a  = ($signed(sum) > $signed(dmax_x)) ? dmax_x : sum;
      sum_b  = ($signed(sum_a) <= $signed(dmin_x)) ? dmin_x : sum_a;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         e_ff   <= e_in;
         de_ff  <= CHG_W'($signed(e_in)) - CHG_W'($signed(prev_e_ff));
         num_ff <= '0;
         den_ff <= '0;
      end
      if (cmd.mem_write || cmd.mem_capture) begin
         if (cmd.chg) begin
            mu_de_ff[cmd.rule] <= cmd.mem_write ? direct_mu : cap_mu;
         end else begin
            mu_e_ff[cmd.rule] <= cmd.mem_write ? direct_mu : cap_mu;
         end
      end
      if (cmd.acc) begin
         num_ff <= num_ff + NUM_W'($signed(prod));
         den_ff <= den_ff + DEN_W'(mu_out);
      end
      if (cmd.finish) begin
         drive_ff <= sum_b[DRIVE_W-1:0];
         none_ff  <= (den_ff == '0);
      end
   end

   // loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_e_ff     <= '0;
         prev_drive_ff <= '0;
      end else if (cmd.finish) begin
         prev_e_ff     <= e_ff;
         prev_drive_ff <= sum_b[DRIVE_W-1:0];
      end
   end

   assign status.mem_direct = w_zero | over;
   assign status.div_done   = div_done;
   assign status.den_zero   = (den_ff == '0);
   assign rsp_drive         = drive_ff;
   assign rsp_no_rule_fired = none_ff;

endmodule

// ----- hw/rtl/fpi_controller.sv -----
module fpi_controller import fpi_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type         state_ff, state_in;
   logic [RULE_W-1:0] rule_ff, rule_in;
   logic              chg_ff, chg_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              step;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rule_ff      <= '0;
         chg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rule_ff      <= rule_in;
         chg_ff       <= chg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rule_in      = rule_ff;
      chg_in       = chg_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd          = '0;
      cmd.rule     = rule_ff;
      cmd.chg      = chg_ff;
      step         = 1'b0;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               rule_in  = '0;
               chg_in   = 1'b0;
               state_in = ST_MEM;
            end
         end
         ST_MEM: begin
            if (status.mem_direct) begin
               cmd.mem_write = 1'b1;
               step          = 1'b1;
            end else begin
               cmd.div_mem = 1'b1;
               state_in    = ST_MEM_WAIT;
            end
         end
         ST_MEM_WAIT: begin
            if (status.div_done) begin
               cmd.mem_capture = 1'b1;
               step            = 1'b1;
            end
         end
         ST_ACC: begin
            cmd.acc = 1'b1;
            if (rule_ff == LAST_RULE) begin
               state_in = ST_CENT;
            end else begin
               rule_in = rule_ff + RULE_W'(1);
            end
         end
         ST_CENT: begin
            if (status.den_zero) begin
               state_in = ST_FIN;
            end else begin
               cmd.div_cent = 1'b1;
               state_in     = ST_CENT_WAIT;
            end
         end
         ST_CENT_WAIT: begin
            if (status.div_done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // result register must be free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // error set then change set of each rule, then accumulate
      if (step) begin
         if (!chg_ff) begin
            chg_in   = 1'b1;
            state_in = ST_MEM;
         end else if (rule_ff == LAST_RULE) begin
            chg_in   = 1'b0;
            rule_in  = '0;
            state_in = ST_ACC;
         end else begin
            chg_in   = 1'b0;
            rule_in  = rule_ff + RULE_W'(1);
            state_in = ST_MEM;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hw/rtl/fuzzy_incremental_pi_controller_unit.sv -----
// Fuzzy incremental PI controller. Each accepted word (setpoint, measured)
// yields one result word: the new drive, clamped to drive_min/drive_max, and
// no_rule_fired when no output rule had any membership (drive held). Items are
// processed one at a time; a single restoring divider sets the latency. After
// the accept cycle, each of the 2*N_RULES memberships is decided directly
// (zero width or outside the set) or needs a divide; then come one accumulate
// step per rule, the centroid step (with its divide, or without one when no
// rule fires) and one finish step.
// The result sits in an output register, so it may wait for rsp_ready while
// the next word is already being processed up to its finish step.
// Configuration writes are taken at any cycle but are meant for idle times.
module fuzzy_incremental_pi_controller_unit import fpi_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [IN_W-1:0]      req_setpoint,
   input  logic [IN_W-1:0]      req_measured,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [DRIVE_W-1:0]   rsp_drive,
   output logic                 rsp_no_rule_fired,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_write_data
);

   cmd_type    cmd;
   status_type status;

   fpi_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   fpi_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_setpoint      (req_setpoint),
      .req_measured      (req_measured),
      .cmd               (cmd),
      .status            (status),
      .rsp_drive         (rsp_drive),
      .rsp_no_rule_fired (rsp_no_rule_fired)
   );

endmodule

// ----- hw/rtl/fpi_checker.sv -----
`include "assert_macros.svh"

module fpi_checker import fpi_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [DRIVE_W-1:0] rsp_drive,
   input logic               rsp_no_rule_fired
);

   // no result word right after reset
   `ASSERT_CLK_ALWAYS(a_rsp_clear_after_reset, reset |=> !rsp_valid)

   // a stalled result word holds
   `ASSERT_CLK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive) && $stable(rsp_no_rule_fired))

   // one word at a time: busy after accept
   `ASSERT_CLK(a_busy_after_accept, req_valid && req_ready |=> !req_ready ##1 !req_ready)

   // a result never appears in the cycle right after an accept
   `ASSERT_CLK(a_no_instant_result, req_valid && req_ready && !rsp_valid |=> !rsp_valid)

endmodule

bind fuzzy_incremental_pi_controller_unit fpi_checker u_fpi_checker (.*);

// ----- bench/tb_fuzzy_incremental_pi_controller_unit.sv -----
module tb_fuzzy_incremental_pi_controller_unit;
   import fpi_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [IN_W-1:0] setpoint;
      logic [IN_W-1:0] measured;
   } sample_word_type;

   typedef struct {
      logic [DRIVE_W-1:0] drive;
      logic               no_rule_fired;
   } drive_word_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [IN_W-1:0]      req_setpoint;
   logic [IN_W-1:0]      req_measured;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [DRIVE_W-1:0]   rsp_drive;
   logic                 rsp_no_rule_fired;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_write_data;

   fuzzy_incremental_pi_controller_unit u_dut (.*);

   sample_word_type pending_samples[$];
   drive_word_type  expected_drives[$];
   int              send_idle_pct;
   int              recv_idle_pct;
   int              mismatch_count;
   int              words_checked;
   int              idle_words;

   // shadow copy of the registers and loop state
   logic [CFG_W-1:0]     sh_err_centers, sh_err_widths, sh_chg_centers, sh_chg_widths;
   logic [CFG_W-1:0]     sh_out_centers;
   logic [HEIGHTS_W-1:0] sh_heights;
   int                   sh_drive_min, sh_drive_max;
   int                   last_error, last_drive;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int field_s(input logic [CFG_W-1:0] r, input int i);
      return int'($signed(r[i*FIELD_W +: FIELD_W]));
   endfunction

   function automatic int field_u(input logic [CFG_W-1:0] r, input int i);
      return int'(r[i*FIELD_W +: FIELD_W]);
   endfunction

   function automatic int triangle(input int x, input int c, input int w, input int h);
      int abs_dist;
      int m;
      abs_dist = (x > c) ? x - c : c - x;
      if (w == 0) return (abs_dist == 0) ? h : 0;
      if (abs_dist > w) return 0;
      m = h - (abs_dist * 32768) / w;
      return (m < 0) ? 0 : m;
   endfunction

   function automatic drive_word_type next_drive(input sample_word_type s);
      drive_word_type r;
      int             mu_e[N_RULES], mu_d[N_RULES], mu_o[N_RULES];
      int             err, chg, he, hd, drv, lo, hi;
      longint         num, den, inc;
      err = int'($signed(s.setpoint)) - int'($signed(s.measured));
      chg = err - last_error;
      he = int'(sh_heights[15:0]);
      hd = int'(sh_heights[31:16]);
      num = 0;
      den = 0;
      drv = last_drive;
      for (int i = 0; i < N_RULES; i++) begin
         mu_e[i] = triangle(err, field_s(sh_err_centers, i), field_u(sh_err_widths, i), he);
         mu_d[i] = triangle(chg, field_s(sh_chg_centers, i), field_u(sh_chg_widths, i), hd);
         mu_o[i] = 0;
      end
      for (int i = 0; i < N_RULES; i++) begin
         if (mu_e[i] != 0 && mu_d[MIDDLE_RULE] != 0) begin
            mu_o[i] = (mu_e[i] > mu_d[MIDDLE_RULE]) ? mu_e[i] : mu_d[MIDDLE_RULE];
         end
      end
      // middle error row overrides
      for (int i = 0; i < N_RULES; i++) begin
         if (mu_e[MIDDLE_RULE] != 0 && mu_d[i] != 0) begin
            mu_o[i] = (mu_e[MIDDLE_RULE] > mu_d[i]) ? mu_e[MIDDLE_RULE] : mu_d[i];
         end
      end
      for (int i = 0; i < N_RULES; i++) begin
         den += mu_o[i];
         num += longint'(mu_o[i]) * field_s(sh_out_centers, i);
      end
      r.no_rule_fired = (den == 0);
      if (den != 0) begin
         inc = num / den;
         lo = field_s(sh_out_centers, 0);
         hi = field_s(sh_out_centers, N_RULES - 1);
         if (inc > hi) inc = hi;
         if (inc <= lo) inc = lo;
         drv = last_drive + int'(inc);
      end
      if (drv > sh_drive_max) drv = sh_drive_max;
      if (drv <= sh_drive_min) drv = sh_drive_min;
      last_error = err;
      last_drive = drv;
      r.drive = drv[DRIVE_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
      mismatch_count++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_setpoint <= '0;
         req_measured <= '0;
      end else if (!req_valid || req_ready) begin
         if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_setpoint <= pending_samples[0].setpoint;
            req_measured <= pending_samples[0].measured;
            void'(pending_samples.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      sample_word_type s;
      if (!reset && req_valid && req_ready) begin
         s.setpoint = req_setpoint;
         s.measured = req_measured;
         expected_drives.push_back(next_drive(s));
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // monitor
   always @(posedge clock) begin
      drive_word_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_drives.size() == 0) begin
            report_mismatch("unexpected result word drive", $signed(rsp_drive), 0);
         end else begin
            w = expected_drives.pop_front();
            words_checked++;
            if (w.no_rule_fired) idle_words++;
            if (rsp_drive !== w.drive)
               report_mismatch("drive", $signed(rsp_drive), $signed(w.drive));
            if (rsp_no_rule_fired !== w.no_rule_fired)
               report_mismatch("no_rule_fired", rsp_no_rule_fired, w.no_rule_fired);
         end
      end
   end

   task automatic csr_write(input csr_index_type idx, input logic [CFG_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx)
         CSR_ERROR_CENTERS:  sh_err_centers = data;
         CSR_ERROR_WIDTHS:   sh_err_widths = data;
         CSR_CHANGE_CENTERS: sh_chg_centers = data;
         CSR_CHANGE_WIDTHS:  sh_chg_widths = data;
         CSR_OUTPUT_CENTERS: sh_out_centers = data;
         CSR_PEAK_HEIGHTS:   sh_heights = data[HEIGHTS_W-1:0];
         CSR_DRIVE_MIN:      sh_drive_min = int'($signed(data[DRIVE_W-1:0]));
         CSR_DRIVE_MAX:      sh_drive_max = int'($signed(data[DRIVE_W-1:0]));
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [CFG_W-1:0] pack5(input int f[5]);
      logic [CFG_W-1:0] r;
      for (int i = 0; i < 5; i++) r[i*FIELD_W +: FIELD_W] = f[i][FIELD_W-1:0];
      return r;
   endfunction

   function automatic int clip12(input int v);
      return (v > 2047) ? 2047 : (v < -2048) ? -2048 : v;
   endfunction

   // spread sets: evenly spaced centers with jitter
   function automatic logic [CFG_W-1:0] spread_centers(input int step);
      int f[5];
      for (int i = 0; i < 5; i++)
         f[i] = clip12((i - 2) * step + $urandom_range(60) - 30);
      return pack5(f);
   endfunction

   function automatic logic [CFG_W-1:0] rand_widths(input int lo, input int hi);
      int f[5];
      for (int i = 0; i < 5; i++) f[i] = $urandom_range(hi, lo);
      return pack5(f);
   endfunction

   task automatic load_settings(input int mode);
      int               oc[5];
      int               t;
      logic [CFG_W-1:0] r;
      for (int i = 0; i < 5; i++) oc[i] = $urandom_range(4095) - 2048;
      if (mode != 3) begin
         for (int i = 0; i < 5; i++)
            for (int j = 0; j < 4 - i; j++)
               if (oc[j] > oc[j+1]) begin
                  t = oc[j];
                  oc[j] = oc[j+1];
                  oc[j+1] = t;
               end
      end
      case (mode)
         1, 4: begin
            csr_write(CSR_ERROR_CENTERS, spread_centers($urandom_range(600, 150)));
            csr_write(CSR_ERROR_WIDTHS, rand_widths(100, 900));
            csr_write(CSR_CHANGE_CENTERS, spread_centers($urandom_range(500, 100)));
            csr_write(CSR_CHANGE_WIDTHS, rand_widths(100, 900));
            csr_write(CSR_PEAK_HEIGHTS, 60'({16'h7FFF, 16'h7FFF}));
            if (mode == 4) begin
               // inverted limits: drive_min wins
               csr_write(CSR_DRIVE_MIN, 60'(16'sd200));
               csr_write(CSR_DRIVE_MAX, 60'(-16'sd200));
            end else begin
               csr_write(CSR_DRIVE_MIN, 60'(16'($urandom_range(30000) - 32000)));
               csr_write(CSR_DRIVE_MAX, 60'(16'($urandom_range(32000, 2000))));
            end
         end
         2: begin
            // zero and full widths, top heights, full drive range
            csr_write(CSR_ERROR_CENTERS, spread_centers(1000));
            csr_write(CSR_ERROR_WIDTHS, pack5('{0, 4095, 1, 4095, 0}));
            csr_write(CSR_CHANGE_CENTERS, pack5('{-2048, -1, 0, 1, 2047}));
            csr_write(CSR_CHANGE_WIDTHS, pack5('{4095, 0, 4095, 2, 4095}));
            csr_write(CSR_PEAK_HEIGHTS, 60'({16'hFFFF, 16'hFFFF}));
            csr_write(CSR_DRIVE_MIN, 60'(-16'sd32768));
            csr_write(CSR_DRIVE_MAX, 60'(16'sd32767));
            oc = '{-2048, -1024, 0, 1024, 2047};
         end
         default: begin
            r = CFG_W'({$urandom, $urandom});
            csr_write(CSR_ERROR_CENTERS, r);
            csr_write(CSR_ERROR_WIDTHS, CFG_W'({$urandom, $urandom}));
            csr_write(CSR_CHANGE_CENTERS, CFG_W'({$urandom, $urandom}));
            csr_write(CSR_CHANGE_WIDTHS, CFG_W'({$urandom, $urandom}));
            csr_write(CSR_PEAK_HEIGHTS, 60'($urandom));
            csr_write(CSR_DRIVE_MIN, CFG_W'({$urandom, $urandom}));
            csr_write(CSR_DRIVE_MAX, CFG_W'({$urandom, $urandom}));
         end
      endcase
      csr_write(CSR_OUTPUT_CENTERS, pack5(oc));
   endtask

   task automatic push_sample(input int sp, input int ms);
      sample_word_type s;
      s.setpoint = sp[IN_W-1:0];
      s.measured = ms[IN_W-1:0];
      pending_samples.push_back(s);
   endtask

   task automatic push_random(input int count, input int err_span);
      int sp;
      for (int k = 0; k < count; k++) begin
         sp = $urandom_range(4095) - 2048;
         if ($urandom_range(99) < 80)
            push_sample(sp, clip12(sp - ($urandom_range(2 * err_span) - err_span)));
         else
            push_sample(sp, $urandom_range(4095) - 2048);
      end
   endtask

   task automatic push_directed();
      push_sample(2047, -2048);
      push_sample(-2048, 2047);
      push_sample(2047, -2048);
      push_sample(0, 0);
      push_sample(0, 0);
      push_sample(2047, 2047);
      push_sample(-2048, -2048);
      push_sample(-1, 0);
      push_sample(0, -1);
      push_sample(1000, 0);
      push_sample(-1000, 0);
      push_sample(-2048, 2047);
   endtask

   task automatic wait_drained();
      while (pending_samples.size() != 0 || req_valid || expected_drives.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      sh_err_centers = '0;
      sh_err_widths = 60'h1001001001001;
      sh_chg_centers = '0;
      sh_chg_widths = 60'h1001001001001;
      sh_out_centers = '0;
      sh_heights = 32'h7FFF7FFF;
      sh_drive_min = -32768;
      sh_drive_max = 32767;
      last_error = 0;
      last_drive = 0;
      mismatch_count = 0;
      words_checked = 0;
      idle_words = 0;
      send_idle_pct = 15;
      recv_idle_pct = 57;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // defaults: only zero error hits the unit-width sets
      push_directed();
      push_random(40, 3);
      wait_drained();

      for (int ph = 1; ph <= 6; ph++) begin
         if (ph == 3) begin
            send_idle_pct = 57;
            recv_idle_pct = 15;
         end else if (ph == 5) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         load_settings((ph == 6) ? 1 : ph % 5);
         if (ph == 2) push_directed();
         push_random(180, (ph == 2) ? 2048 : 900);
         wait_drained();
      end

      repeat (400) @(posedge clock);
      $display("checked %0d result words over 7 register settings, %0d with no rule firing",
               words_checked, idle_words);
      $display("settings covered zero/full widths, inverted drive limits, random registers");
      if (mismatch_count == 0 && expected_drives.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout with %0d words outstanding", expected_drives.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
